// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks that prop holds at every rising edge of clk outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that expr is never true at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// File: rtl/hssd_pkg.sv
// ---------------------------------------------------------------------------
// Half-step stepper driver package
// Shared widths, codes, the half-step coil table and divider status type.
// ---------------------------------------------------------------------------
package hssd_pkg;

   localparam int TF_W      = 20;   // timer frequency, dividend of both divisions
   localparam int LIM_W     = 15;   // speed limit, threshold, divisor width
   localparam int SPEED_W   = 16;
   localparam int COIL_W    = 4;
   localparam int POS_W     = 32;
   localparam int MOTION_W  = 2;
   localparam int PHASE_W   = 3;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   localparam logic [15:0] HALT_INTERVAL = 16'hffff;

   typedef logic [MOTION_W-1:0]  motion_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam motion_type MOT_HALT = 2'd0;
   localparam motion_type MOT_FWD  = 2'd1;
   localparam motion_type MOT_BWD  = 2'd2;

   localparam csr_index_type CSR_TIMER_FREQ     = 2'd0;
   localparam csr_index_type CSR_SPEED_LIMIT    = 2'd1;
   localparam csr_index_type CSR_SAVE_THRESHOLD = 2'd2;
   localparam csr_index_type CSR_INVERT         = 2'd3;

   localparam logic OP_TICK      = 1'b0;
   localparam logic OP_SET_SPEED = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Half-step coil patterns, bit 0 is the first coil column.
   function automatic logic [COIL_W-1:0] half_step_coils(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pattern;
      case (phase)
         3'd0:    pattern = 4'd5;
         3'd1:    pattern = 4'd4;
         3'd2:    pattern = 4'd6;
         3'd3:    pattern = 4'd2;
         3'd4:    pattern = 4'd10;
         3'd5:    pattern = 4'd8;
         3'd6:    pattern = 4'd9;
         3'd7:    pattern = 4'd1;
         default: pattern = 4'd0;
      endcase
      return pattern;
   endfunction

endpackage

// File: rtl/hssd_div.sv
// ---------------------------------------------------------------------------
// Bit-serial restoring divider
// Produces one quotient bit per cycle of a timer-frequency-wide dividend.
// ---------------------------------------------------------------------------
module hssd_div
   import hssd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [TF_W-1:0]  dividend,
   input  logic [LIM_W-1:0] divisor,
   output logic [TF_W-1:0]  quotient,
   output div_status_type   status
);

   localparam int CNT_W = $clog2(TF_W + 1);

   logic [TF_W-1:0]  quot_ff, quot_in;
   logic [LIM_W-1:0] rem_ff, rem_in;
   logic [LIM_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [LIM_W:0]   trial;
   logic             fits;

   // The dividend shifts out at the top while quotient bits shift in below.
   assign trial = {rem_ff, quot_ff[TF_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(TF_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[TF_W-2:0], fits};
         rem_in  = fits ? LIM_W'(trial - {1'b0, dvs_ff}) : trial[LIM_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient    = quot_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/half_step_stepper_driver_core.sv
// A timer tick transaction passes from the idle state through the tick state into
// the output register; a speed command passes through the clamp, divide and finish
// states and waits in the divide state on the two 20-step bit-serial dividers that
// run side by side. A new transaction is taken only once the sequencer is idle again.
// Results wait in an output register, so a stalled result side only holds the block.
// Reset (synchronous, active high) restores the register defaults, halts the motor,
// drives all coils off and clears the position counter.
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Half-step stepper driver core
// Sequences one bipolar stepper through an 8-entry half-step table from timer
// ticks and signed speed commands, with clamp, direction and power save.
// ---------------------------------------------------------------------------
module half_step_stepper_driver_core
   import hssd_pkg::*;
#(
   parameter int PERIOD_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Request stream.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [15:0] speed (signed)
   input  logic                   req_tuser,   // [0] opcode
   // Result stream.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [3:0] coils, [35:4] position,
                                               // [37:36] motion, [38] stepped, [39] zero
   // Configuration write channel.
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [TF_W-1:0]        csr_data
);

   // Counter range. The quotients are at most TF_W bits wide, so the saturation
   // compare is done at whichever width is larger.
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;
   localparam logic [PERIOD_BITS-1:0] HALT_IV    = PERIOD_BITS'(HALT_INTERVAL);
   localparam int WIDE_W = (PERIOD_BITS > TF_W) ? PERIOD_BITS : TF_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TICK  = 3'd1;
   localparam logic [2:0] ST_CLAMP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [TF_W-1:0] q);
      logic [WIDE_W-1:0] qw;
      qw = WIDE_W'(q);
      if (qw > WIDE_W'(PERIOD_MAX)) sat_period = PERIOD_MAX;
      else sat_period = qw[PERIOD_BITS-1:0];
   endfunction

   // Configuration registers.
   logic [TF_W-1:0]   freq_ff;
   logic [LIM_W-1:0]  limit_ff;
   logic [LIM_W-1:0]  thresh_ff;
   logic              invert_ff;

   // Motor state.
   logic [2:0]             state_ff, state_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [POS_W-1:0]       count_ff, count_in;
   motion_type             motion_ff, motion_in;
   logic [PERIOD_BITS-1:0] interval_ff, interval_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   save_en_ff, save_en_in;
   logic [PERIOD_BITS-1:0] save_cmp_ff, save_cmp_in;
   logic [COIL_W-1:0]      coil_ff, coil_in;

   // Latched request and the clamped command waiting for the dividers.
   logic                   op_ff;
   logic [SPEED_W-1:0]     speed_ff;
   motion_type             pend_motion_ff, pend_motion_in;
   logic                   pend_save_ff, pend_save_in;
   logic [LIM_W-1:0]       mag_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic                   slot_free;
   logic                   load;
   logic                   tick_commit;
   logic                   stepped;

   // Tick datapath.
   logic [PERIOD_BITS:0]   next_count;
   logic                   ended;
   logic                   moving;
   logic                   up;

   // Clamp datapath.
   logic                   neg;
   logic [SPEED_W-1:0]     abs_speed;

   // Dividers: timer frequency over speed magnitude, and over the threshold.
   logic                   div_start;
   logic [TF_W-1:0]        q_speed, q_save;
   div_status_type         st_speed, st_save;

   // Divider status summaries used by the checks below.
   logic                   div_busy;
   logic                   div_done_any;
   logic                   div_done_ok;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration writes. Indexes beyond the list do not exist with this width.
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff   <= TF_W'(100000);
         limit_ff  <= LIM_W'(1100);
         thresh_ff <= LIM_W'(650);
         invert_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMER_FREQ:     freq_ff   <= csr_data;
            CSR_SPEED_LIMIT:    limit_ff  <= csr_data[LIM_W-1:0];
            CSR_SAVE_THRESHOLD: thresh_ff <= csr_data[LIM_W-1:0];
            CSR_INVERT:         invert_ff <= csr_data[0];
            default:            ;
         endcase
      end
   end

   // The period ends when the incremented count reaches the interval. A zero
   // interval therefore ends a period on every tick.
   assign next_count = {1'b0, period_ff} + 1'b1;
   assign ended      = next_count >= {1'b0, interval_ff};
   assign moving     = (motion_ff == MOT_FWD) || (motion_ff == MOT_BWD);
   assign up         = (motion_ff == MOT_FWD) ^ invert_ff;

   // Clamp of the signed command against the limit. The magnitude of the most
   // negative speed still fits in SPEED_W unsigned bits.
   assign neg       = speed_ff[SPEED_W-1];
   assign abs_speed = neg ? SPEED_W'(-speed_ff) : speed_ff;
   assign mag_in    = (abs_speed > {1'b0, limit_ff}) ? limit_ff : abs_speed[LIM_W-1:0];

   always_comb begin
      if (mag_in == '0) pend_motion_in = MOT_HALT;
      else if (neg) pend_motion_in = MOT_BWD;
      else pend_motion_in = MOT_FWD;
   end
   assign pend_save_in = mag_in < thresh_ff;

   assign div_start = (state_ff == ST_CLAMP);

   hssd_div u_div_speed (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (freq_ff),
      .divisor  (mag_in),
      .quotient (q_speed),
      .status   (st_speed)
   );

   hssd_div u_div_save (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (freq_ff),
      .divisor  (thresh_ff),
      .quotient (q_save),
      .status   (st_save)
   );

   // Main sequencer. A result is committed only when the output register can take
   // it, and the motor state is updated in that same cycle.
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      motion_in   = motion_ff;
      interval_in = interval_ff;
      period_in   = period_ff;
      save_en_in  = save_en_ff;
      save_cmp_in = save_cmp_ff;
      coil_in     = coil_ff;
      load        = 1'b0;
      tick_commit = 1'b0;
      stepped     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == OP_SET_SPEED) ? ST_CLAMP : ST_TICK;
            end
         end
         ST_TICK: begin
            if (slot_free) begin
               load        = 1'b1;
               tick_commit = 1'b1;
               stepped     = ended;
               state_in    = ST_IDLE;
               if (ended) begin
                  period_in = '0;
                  if (moving) begin
                     if (up) begin
                        phase_in = phase_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                     end else begin
                        phase_in = phase_ff - 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                     coil_in = half_step_coils(phase_in);
                  end else begin
                     coil_in = '0;
                  end
               end else begin
                  period_in = next_count[PERIOD_BITS-1:0];
               end
               // Power save clears the coils even on a tick that stepped.
               if (save_en_ff && (period_in == save_cmp_ff)) begin
                  coil_in = '0;
               end
            end
         end
         ST_CLAMP: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (st_speed.done) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               load      = 1'b1;
               state_in  = ST_IDLE;
               motion_in = pend_motion_ff;
               if (pend_motion_ff == MOT_HALT) begin
                  // Halting leaves the coils and the compare value as they are.
                  interval_in = HALT_IV;
                  save_en_in  = 1'b0;
               end else begin
                  interval_in = sat_period(q_speed);
                  if (thresh_ff == '0) begin
                     save_cmp_in = PERIOD_MAX;
                     save_en_in  = 1'b0;
                  end else begin
                     save_cmp_in = sat_period(q_save);
                     save_en_in  = pend_save_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_data_in  = load ? {1'b0, stepped, motion_in, count_in, coil_in} : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         count_ff     <= '0;
         motion_ff    <= MOT_HALT;
         interval_ff  <= HALT_IV;
         period_ff    <= '0;
         save_en_ff   <= 1'b0;
         save_cmp_ff  <= '0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         motion_ff    <= motion_in;
         interval_ff  <= interval_in;
         period_ff    <= period_in;
         save_en_ff   <= save_en_in;
         save_cmp_ff  <= save_cmp_in;
         coil_ff      <= coil_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         op_ff    <= req_tuser;
         speed_ff <= req_tdata;
      end
      if (state_ff == ST_CLAMP) begin
         pend_motion_ff <= pend_motion_in;
         pend_save_ff   <= pend_save_in;
      end
   end

   assign div_busy     = st_speed.busy || st_save.busy;
   assign div_done_any = st_speed.done || st_save.done;
   assign div_done_ok  = (state_ff == ST_DIV) && st_speed.done && st_save.done &&
                         (op_ff == OP_SET_SPEED);

   // A new transaction is never accepted while a division is still running.
   `ASSERT_NEVER(a_no_accept_during_div, clock, reset, req_fire && div_busy, "accept while busy")

   // Both dividers start together and finish together, only while waiting on them.
   `ASSERT_CLK(a_div_done_in_wait, clock, reset, div_done_any |-> div_done_ok, "stray div done")

   // The position only moves on a committed tick.
   `ASSERT_CLK(a_position_on_tick, clock, reset, !tick_commit |=> $stable(count_ff), "bad move")

endmodule
